// ----- sv/tts_pkg.sv -----
// Shared types and constants for the periodic task tick scheduler.
package tts_pkg;

  // Table size and reload offset
  localparam int TASK_COUNT    = 8;
  localparam int RELOAD_OFFSET = 1;

  // Scan step width and the width used to compare a step with a slot number
  localparam int IDX_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam int CMP_W = (IDX_W > 3) ? IDX_W : 3;

  // Most firings reported for one tick
  localparam logic [3:0] MAX_REPORTS = 4'd8;

  localparam logic [15:0] RELOAD_SUB = 16'(RELOAD_OFFSET);

  // Command codes
  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_SUSPEND = 2'd1,
    KIND_TICK    = 2'd2
  } kind_t;

  // One task slot
  typedef struct packed {
    logic        occ;
    logic        susp;
    logic [15:0] per;
    logic [15:0] cnt;
  } entry_t;

  // Command seen by the head update unit
  typedef struct packed {
    logic [1:0]  kind;
    logic        hit;
    logic [15:0] period;
    logic [15:0] first_delay;
  } head_cmd_t;

  // Outcome of one head update
  typedef struct packed {
    logic fire;
    logic refuse;
  } head_flags_t;

endpackage

// ----- sv/tts_cell.sv -----
// One task slot cell of the rotating slot ring.
module tts_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  tts_pkg::entry_t d,
  output tts_pkg::entry_t q
);

  tts_pkg::entry_t entry;

  // Take the neighbor's slot on every scan step
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift_en) begin
      entry <= d;
    end
  end

  assign q = entry;

endmodule

// ----- sv/tts_head.sv -----
// Update unit for the slot at the head of the ring.
module tts_head (
  input  tts_pkg::entry_t     cur,
  input  tts_pkg::head_cmd_t  cmd,
  output tts_pkg::entry_t     upd,
  output tts_pkg::head_flags_t flags
);

  always_comb begin
    upd          = cur;
    flags.fire   = 1'b0;
    flags.refuse = 1'b0;
    case (cmd.kind)
      tts_pkg::KIND_CREATE: begin
        // Fill a free slot, refuse an occupied one
        if (cmd.hit) begin
          if (cur.occ) begin
            flags.refuse = 1'b1;
          end else begin
            upd.occ  = 1'b1;
            upd.susp = 1'b0;
            upd.per  = cmd.period;
            upd.cnt  = cmd.first_delay;
          end
        end
      end
      tts_pkg::KIND_SUSPEND: begin
        if (cmd.hit) begin
          upd.susp = 1'b1;
        end
      end
      tts_pkg::KIND_TICK: begin
        // For an active slot, fire and reload at zero, otherwise count down
        if (cur.occ && !cur.susp) begin
          if (cur.cnt == 16'd0) begin
            upd.cnt    = cur.per - tts_pkg::RELOAD_SUB;
            flags.fire = 1'b1;
          end else begin
            upd.cnt = cur.cnt - 16'd1;
          end
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

endmodule

// ----- sv/periodic_task_tick_scheduler_top.sv -----
// Top level of the periodic task tick scheduler: slot ring, head unit, control.
//
// Usage: drive kind, slot, period and first_delay and raise start; the command
// is taken at a clock edge where start is high and busy is low. Kinds are
// create, suspend and tick; the unused code is taken and ignored with no result.
// The slot table is a ring of TASK_COUNT cells that rotates by one cell per
// cycle while a command walks it; the head unit updates the slot passing
// through it, so every command walks the whole ring once and the table ends in
// its original order. Busy rises when a create, suspend or tick is taken and
// stays high through the ring walk and the state that emits the final result,
// so a new command is not taken until the walk is over.
// Results appear on task_slot, fired, status and last for one cycle, marked by
// strobe. A create or suspend gives one result. A tick gives one result per
// firing in slot order (at most eight), the last marked by last; each firing is
// held until the next one turns up or the walk ends, so the final one can carry
// last. A tick with no firing gives one empty result with last set. The final
// result of a command is shown in the first cycle with busy low again.
// The receiver cannot stall results.
// Reset (rst, synchronous) empties every slot and returns control to idle.
module periodic_task_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [2:0]  slot,
  input  logic [15:0] period,
  input  logic [15:0] first_delay,
  output logic        strobe,
  output logic [2:0]  task_slot,
  output logic        fired,
  output logic        status,
  output logic        last
);

  localparam int N = tts_pkg::TASK_COUNT;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  // Latched command
  logic [1:0]  cmd_kind;
  logic [2:0]  cmd_slot;
  logic [15:0] cmd_period;
  logic [15:0] cmd_delay;

  logic [tts_pkg::IDX_W-1:0] step;
  logic [tts_pkg::CMP_W-1:0] step_ext;
  logic                      hit;

  // Tick bookkeeping and create outcome
  logic       pend_valid;
  logic [2:0] pend_slot;
  logic [3:0] fire_count;
  logic       create_ok;

  tts_pkg::entry_t      ring_q [N];
  tts_pkg::entry_t      head_upd;
  tts_pkg::head_cmd_t   head_cmd;
  tts_pkg::head_flags_t head_flags;
  logic                 shift_en;
  logic                 accept;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign shift_en = (state == ST_RUN);
  assign step_ext = tts_pkg::CMP_W'(step);
  assign hit      = (step_ext == tts_pkg::CMP_W'(cmd_slot));

  // Build the ring: each cell takes its upper neighbor, the top takes the head
  for (genvar k = 0; k < N; k++) begin : g_ring
    tts_pkg::entry_t d;
    if (k == N - 1) begin : g_top
      assign d = head_upd;
    end else begin : g_mid
      assign d = ring_q[k+1];
    end
    tts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (shift_en),
      .d        (d),
      .q        (ring_q[k])
    );
  end

  assign head_cmd.kind        = cmd_kind;
  assign head_cmd.hit         = hit;
  assign head_cmd.period      = cmd_period;
  assign head_cmd.first_delay = cmd_delay;

  tts_head u_head (
    .cur   (ring_q[0]),
    .cmd   (head_cmd),
    .upd   (head_upd),
    .flags (head_flags)
  );

  // Latch the command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind   <= kind;
      cmd_slot   <= slot;
      cmd_period <= period;
      cmd_delay  <= first_delay;
    end
  end

  // Sequence the ring walk and emit results
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      pend_valid <= 1'b0;
      pend_slot  <= '0;
      fire_count <= '0;
      create_ok  <= 1'b0;
      strobe     <= 1'b0;
      task_slot  <= '0;
      fired      <= 1'b0;
      status     <= 1'b0;
      last       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (kind == tts_pkg::KIND_CREATE || kind == tts_pkg::KIND_SUSPEND ||
                         kind == tts_pkg::KIND_TICK)) begin
            state      <= ST_RUN;
            step       <= '0;
            pend_valid <= 1'b0;
            fire_count <= '0;
            create_ok  <= 1'b0;
          end
        end
        ST_RUN: begin
          if (cmd_kind == tts_pkg::KIND_CREATE && hit && !head_flags.refuse) begin
            create_ok <= 1'b1;
          end
          // Hold one firing back; release the held one when another shows up
          if (head_flags.fire && fire_count < tts_pkg::MAX_REPORTS) begin
            if (pend_valid) begin
              strobe    <= 1'b1;
              task_slot <= pend_slot;
              fired     <= 1'b1;
              status    <= 1'b0;
              last      <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_slot  <= step_ext[2:0];
            fire_count <= fire_count + 4'd1;
          end
          if (step == tts_pkg::IDX_W'(N - 1)) begin
            state <= ST_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DONE: begin
          // Emit the final result of the command
          strobe <= 1'b1;
          last   <= 1'b1;
          if (cmd_kind == tts_pkg::KIND_TICK) begin
            task_slot <= pend_valid ? pend_slot : 3'd0;
            fired     <= pend_valid;
            status    <= 1'b0;
          end else begin
            task_slot <= cmd_slot;
            fired     <= 1'b0;
            status    <= (cmd_kind == tts_pkg::KIND_CREATE) && !create_ok;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A firing report never carries a refusal
  a_fire_no_refuse: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(fired && status))
    else $error("firing result marked refused");

  // Every walk ends in exactly one final result
  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> (strobe && last))
    else $error("walk ended without a final result");

  // Results that are not final only come from tick firings
  a_mid_is_fire: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (fired && cmd_kind == tts_pkg::KIND_TICK))
    else $error("non-final result that is not a firing");

  // The final result leaves the block free for the next command
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final result while still busy");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

endmodule
